/* design/lpfp_pkg.sv */
// Shared types and constants for the length-prefixed frame parser.
`timescale 1ns / 1ps

package lpfp_pkg;

  // Stream constants.
  localparam int unsigned LENGTH_BYTES = 4;
  localparam logic [7:0] MARK_FIRST = 8'h59;
  localparam logic [7:0] MARK_SECOND = 8'h48;
  localparam logic [1:0] LEN_CNT_LAST = 2'(LENGTH_BYTES - 1);

  // Register file layout.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_MAX_BODY_LENGTH = 1'b0;
  localparam logic [31:0] MAX_BODY_LENGTH_RESET = 32'd65536;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_MARK2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_BODY = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // Configuration seen by the parser core.
  typedef struct packed {
    logic [31:0] max_body_length;
  } cfg_t;

endpackage

/* design/lpfp_in_if.sv */
// Byte channel into the frame parser.
`timescale 1ns / 1ps

interface lpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* design/lpfp_out_if.sv */
// Result channel out of the frame parser.
`timescale 1ns / 1ps

interface lpfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] body_byte;
  logic       body_last;

  modport source (output valid, output status, output body_byte, output body_last,
                  input ready);
  modport sink (input valid, input status, input body_byte, input body_last,
                output ready);
endinterface

/* design/lpfp_regs.sv */
// APB-style configuration register file of the frame parser.
`timescale 1ns / 1ps

module lpfp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [lpfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [lpfp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output lpfp_pkg::cfg_t                cfg
);

  logic [31:0] max_body_length;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= lpfp_pkg::MAX_BODY_LENGTH_RESET;
    end else if (wr_en && paddr[2] == lpfp_pkg::REG_MAX_BODY_LENGTH) begin
      max_body_length <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      lpfp_pkg::REG_MAX_BODY_LENGTH: prdata = max_body_length;
      default:                       prdata = '0;
    endcase
  end

  assign cfg.max_body_length = max_body_length;

endmodule

/* design/lpfp_core.sv */
// Frame parser core: input register, marker/length/body logic, result register.
`timescale 1ns / 1ps

module lpfp_core (
  input  logic             clk,
  input  logic             rst,
  input  lpfp_pkg::cfg_t   cfg,
  lpfp_in_if.sink          byte_in,
  lpfp_out_if.source       frame_out
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Parser state.
  lpfp_pkg::phase_t phase, phase_next;
  logic [31:0] length_shift, length_shift_next;
  logic [1:0]  length_bytes_seen, length_bytes_seen_next;
  logic [31:0] body_remaining, body_remaining_next;

  // Result register.
  logic       res_valid;
  logic [1:0] res_status;
  logic [7:0] res_byte;
  logic       res_last;

  logic        advance;
  logic [31:0] len_full;
  logic        len_done;
  logic        len_over;
  logic        len_zero;
  logic        body_end;
  logic        emit;
  logic [1:0]  emit_status;
  logic [7:0]  emit_byte;
  logic        emit_last;

  // The registered byte moves on whenever the result register is free or drains now.
  assign advance       = s1_valid && (!res_valid || frame_out.ready);
  assign byte_in.ready = !s1_valid || advance;

  assign len_full = length_shift | ({24'd0, s1_byte} << {length_bytes_seen, 3'b000});
  assign len_done = (length_bytes_seen == lpfp_pkg::LEN_CNT_LAST);
  assign len_over = len_full > cfg.max_body_length;
  assign len_zero = (len_full == 32'd0);
  assign body_end = (body_remaining <= 32'd1);

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      lpfp_pkg::PH_HUNT: begin
        if (s1_byte == lpfp_pkg::MARK_FIRST) phase_next = lpfp_pkg::PH_MARK2;
      end
      lpfp_pkg::PH_MARK2: begin
        phase_next = (s1_byte == lpfp_pkg::MARK_SECOND) ? lpfp_pkg::PH_LEN
                                                         : lpfp_pkg::PH_HUNT;
      end
      lpfp_pkg::PH_LEN: begin
        if (len_done) begin
          phase_next = (len_over || len_zero) ? lpfp_pkg::PH_HUNT : lpfp_pkg::PH_BODY;
        end
      end
      lpfp_pkg::PH_BODY: begin
        if (body_end) phase_next = lpfp_pkg::PH_HUNT;
      end
      default: phase_next = lpfp_pkg::PH_HUNT;
    endcase
  end

  // Datapath and result outputs.
  always_comb begin
    length_shift_next      = length_shift;
    length_bytes_seen_next = length_bytes_seen;
    body_remaining_next    = body_remaining;
    emit        = 1'b0;
    emit_status = lpfp_pkg::ST_BODY;
    emit_byte   = 8'd0;
    emit_last   = 1'b0;
    unique case (phase)
      lpfp_pkg::PH_HUNT: begin
      end
      lpfp_pkg::PH_MARK2: begin
        if (s1_byte == lpfp_pkg::MARK_SECOND) begin
          length_shift_next      = 32'd0;
          length_bytes_seen_next = 2'd0;
        end
      end
      lpfp_pkg::PH_LEN: begin
        if (len_done) begin
          length_shift_next      = 32'd0;
          length_bytes_seen_next = 2'd0;
          if (len_over) begin
            emit        = 1'b1;
            emit_status = lpfp_pkg::ST_REJECT;
          end else if (len_zero) begin
            emit        = 1'b1;
            emit_status = lpfp_pkg::ST_EMPTY;
          end else begin
            body_remaining_next = len_full;
          end
        end else begin
          length_shift_next      = len_full;
          length_bytes_seen_next = length_bytes_seen + 2'd1;
        end
      end
      lpfp_pkg::PH_BODY: begin
        emit        = 1'b1;
        emit_status = lpfp_pkg::ST_BODY;
        emit_byte   = s1_byte;
        emit_last   = body_end;
        body_remaining_next = body_end ? 32'd0 : body_remaining - 32'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_byte <= byte_in.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lpfp_pkg::PH_HUNT;
      length_shift      <= 32'd0;
      length_bytes_seen <= 2'd0;
      body_remaining    <= 32'd0;
    end else if (advance) begin
      phase             <= phase_next;
      length_shift      <= length_shift_next;
      length_bytes_seen <= length_bytes_seen_next;
      body_remaining    <= body_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end else if (frame_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_status <= emit_status;
      res_byte   <= emit_byte;
      res_last   <= emit_last;
    end
  end

  assign frame_out.valid     = res_valid;
  assign frame_out.status    = res_status;
  assign frame_out.body_byte = res_byte;
  assign frame_out.body_last = res_last;

endmodule

/* design/length_prefixed_frame_parser_top.sv */
// Top level of the length-prefixed frame parser.
`timescale 1ns / 1ps

// Channel     Direction  Handshake        Payload
// byte_in     in         valid / ready    data_byte[7:0]
// frame_out   out        valid / ready    status[1:0], body_byte[7:0], body_last
// APB         in/out     psel, penable    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// An accepted item sits in the input register, where the parsing logic works on it; its
// result, if any, is loaded into the result register when the item moves on.
// One item is accepted per cycle; the result register separates the two sides, so
// the byte stream only stalls while a finished result is waiting and frame_out is not ready.
// The rate is set by the phase update, which is combinational (marker match, length
// gather and the 32-bit compare against max_body_length).
// Synchronous reset returns the parser to hunting for the first marker byte and sets
// max_body_length to 65536; no clearing pass is needed.

module length_prefixed_frame_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  lpfp_in_if.sink                       byte_in,
  lpfp_out_if.source                    frame_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [lpfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [lpfp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Parser configuration; the user makes changes only while the parser is idle; unenforced.
  lpfp_pkg::cfg_t cfg;

  // Register file: holds max_body_length at byte address 0.
  lpfp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parser core: input register, phase logic and result register.
  lpfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .byte_in   (byte_in),
    .frame_out (frame_out)
  );

endmodule

/* design/lpfp_checker.sv */
// Port-level checks for the frame parser, bound to its top level.
`timescale 1ns / 1ps

module lpfp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [7:0]                    out_body_byte,
  input logic                          out_body_last,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [lpfp_pkg::PADDR_W-1:0]  paddr,
  input logic [lpfp_pkg::PDATA_W-1:0]  pwdata,
  input logic [lpfp_pkg::PDATA_W-1:0]  prdata
);

  // Empty-frame and reject results carry no byte and no end mark.
  a_nonbody_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != lpfp_pkg::ST_BODY) |-> (out_body_byte == 8'd0 && !out_body_last))
    else $error("non-body result carries byte data");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_body_byte) && $stable(out_body_last)))
    else $error("stalled result changed");

  // After reset the maximum length register reads its reset value.
  a_reset_value: assert property (@(posedge clk)
    rst |=> (paddr[2] != lpfp_pkg::REG_MAX_BODY_LENGTH ||
             prdata == lpfp_pkg::MAX_BODY_LENGTH_RESET))
    else $error("max_body_length reset value wrong");

  // A write to the maximum length register reads back on the next cycle.
  a_write_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == lpfp_pkg::REG_MAX_BODY_LENGTH) |=>
      (paddr[2] != lpfp_pkg::REG_MAX_BODY_LENGTH || prdata == $past(pwdata)))
    else $error("max_body_length write not visible");

endmodule

bind length_prefixed_frame_parser_top lpfp_checker u_lpfp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (frame_out.valid),
  .out_ready     (frame_out.ready),
  .out_status    (frame_out.status),
  .out_body_byte (frame_out.body_byte),
  .out_body_last (frame_out.body_last),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

/* bench/tb.sv */
// Self-checking testbench for the length-prefixed frame parser top level.
`timescale 1ns / 1ps

module tb;

  // One result item as it appears on frame_out.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] body_byte;
    logic       body_last;
  } frame_result_t;

  // A row of the directed table. Rows with a typed result carry the expectation
  // that goes into the scoreboard; the others are left to the parser model below.
  typedef struct packed {
    logic [7:0]    data;
    logic          typed;
    logic          has_result;
    frame_result_t result;
  } stim_row_t;

  localparam frame_result_t NO_RESULT   = '0;
  localparam frame_result_t EMPTY_FRAME = '{lpfp_pkg::ST_EMPTY, 8'h00, 1'b0};
  localparam frame_result_t OVERSIZE    = '{lpfp_pkg::ST_REJECT, 8'h00, 1'b0};

  localparam logic [lpfp_pkg::PADDR_W-1:0] ADDR_MAX_LEN =
    lpfp_pkg::PADDR_W'(lpfp_pkg::REG_MAX_BODY_LENGTH) << 2;
  localparam logic [lpfp_pkg::PADDR_W-1:0] ADDR_UNUSED =
    ADDR_MAX_LEN + lpfp_pkg::PADDR_W'(4);

  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 150;  // receiver hold-off that backs up the input
  localparam int DIRECTED_N   = 25;

  localparam stim_row_t DIRECTED [DIRECTED_N] = '{
    // Bytes while hunting give nothing.
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b0, NO_RESULT},
    // A second 'Y' in place of 'H' is dropped, so the 'H' after it is only hunted.
    '{lpfp_pkg::MARK_FIRST, 1'b1, 1'b0, NO_RESULT},
    '{lpfp_pkg::MARK_FIRST, 1'b1, 1'b0, NO_RESULT},
    '{lpfp_pkg::MARK_SECOND, 1'b1, 1'b0, NO_RESULT},
    // Zero-length frame.
    '{lpfp_pkg::MARK_FIRST, 1'b1, 1'b0, NO_RESULT},
    '{lpfp_pkg::MARK_SECOND, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b1, EMPTY_FRAME},
    // All-ones length, which a signed reading would take as negative.
    '{lpfp_pkg::MARK_FIRST, 1'b1, 1'b0, NO_RESULT},
    '{lpfp_pkg::MARK_SECOND, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b1, OVERSIZE},
    // Two-byte body carrying the byte extremes.
    '{lpfp_pkg::MARK_FIRST, 1'b0, 1'b0, NO_RESULT},
    '{lpfp_pkg::MARK_SECOND, 1'b0, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b1, '{lpfp_pkg::ST_BODY, 8'h00, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{lpfp_pkg::ST_BODY, 8'hFF, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lpfp_pkg::PADDR_W-1:0] paddr;
  logic [lpfp_pkg::PDATA_W-1:0] pwdata;
  logic [lpfp_pkg::PDATA_W-1:0] prdata;
  logic pready;

  lpfp_in_if  byte_in ();
  lpfp_out_if frame_out ();

  length_prefixed_frame_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in.sink),
    .frame_out (frame_out.source),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser model state and the configuration it runs under.
  lpfp_pkg::phase_t parse_phase;
  logic [31:0] len_accum;
  logic [1:0]  len_count;
  logic [31:0] body_left;
  logic [31:0] max_body_len;

  frame_result_t pending_results[$];
  int  error_count;
  int  frame_items;
  bit  no_idle;
  bit  hold_req;

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 200) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  // Advances the parser model by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t res);
    bit hit;
    hit = 1'b0;
    res = NO_RESULT;
    case (parse_phase)
      lpfp_pkg::PH_HUNT: begin
        if (b == lpfp_pkg::MARK_FIRST) parse_phase = lpfp_pkg::PH_MARK2;
      end
      lpfp_pkg::PH_MARK2: begin
        if (b == lpfp_pkg::MARK_SECOND) begin
          parse_phase = lpfp_pkg::PH_LEN;
          len_accum = '0;
          len_count = '0;
        end else begin
          parse_phase = lpfp_pkg::PH_HUNT;
        end
      end
      lpfp_pkg::PH_LEN: begin
        len_accum = len_accum | (32'(b) << (8 * len_count));
        if (len_count == lpfp_pkg::LEN_CNT_LAST) begin
          len_count = '0;
          if (len_accum > max_body_len) begin
            parse_phase = lpfp_pkg::PH_HUNT;
            hit = 1'b1;
            res = OVERSIZE;
          end else if (len_accum == 32'd0) begin
            parse_phase = lpfp_pkg::PH_HUNT;
            hit = 1'b1;
            res = EMPTY_FRAME;
          end else begin
            body_left = len_accum;
            parse_phase = lpfp_pkg::PH_BODY;
          end
          len_accum = '0;
        end else begin
          len_count = len_count + 2'd1;
        end
      end
      default: begin
        hit = 1'b1;
        res.status = lpfp_pkg::ST_BODY;
        res.body_byte = b;
        if (body_left <= 32'd1) begin
          body_left = '0;
          parse_phase = lpfp_pkg::PH_HUNT;
          res.body_last = 1'b1;
        end else begin
          body_left = body_left - 32'd1;
          res.body_last = 1'b0;
        end
      end
    endcase
    return hit;
  endfunction

  // Offers one byte, possibly after a random gap, and files its expectation once
  // the byte is taken. A typed row overrides the model's answer in the scoreboard.
  task automatic send_byte(input logic [7:0] b, input logic typed, input logic typed_has,
                           input frame_result_t typed_res);
    frame_result_t res;
    bit hit;
    if (!no_idle && !hold_req && $urandom_range(0, 9) == 0) begin
      byte_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.data_byte <= b;
    do @(posedge clk); while (!byte_in.ready);
    hit = parse_byte(b, res);
    if (typed) begin
      hit = typed_has;
      res = typed_res;
    end
    if (hit) pending_results.push_back(res);
  endtask

  // Marker, little-endian length, then body_n random body bytes.
  task automatic send_frame(input logic [31:0] len, input int body_n);
    send_byte(lpfp_pkg::MARK_FIRST, 1'b0, 1'b0, NO_RESULT);
    send_byte(lpfp_pkg::MARK_SECOND, 1'b0, 1'b0, NO_RESULT);
    for (int i = 0; i < 4; i++) begin
      send_byte(len[8*i +: 8], 1'b0, 1'b0, NO_RESULT);
    end
    for (int i = 0; i < body_n; i++) begin
      send_byte(8'($urandom()), 1'b0, 1'b0, NO_RESULT);
    end
    frame_items += 6 + body_n;
  endtask

  // Stops offering and waits until every expected result has come out, then lets
  // a byte still in flight that gives no result clear the pipeline.
  task automatic drain_results();
    byte_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [lpfp_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MAX_LEN) max_body_len = data;
  endtask

  // Reads the length limit back and checks it against the model's copy.
  task automatic check_max_len();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MAX_LEN;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== max_body_len) begin
      note_error($sformatf("max_body_length reads %h, expected %h", prdata, max_body_len));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: mostly well-formed frames, plus oversize headers, broken
  // markers and stray bytes. Only frame and oversize-header bytes count toward quota.
  task automatic run_traffic(input int quota);
    int stop_at;
    int pick;
    logic [31:0] len;
    logic [31:0] cap;
    logic [7:0] b;
    stop_at = frame_items + quota;
    while (frame_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 || (pick < 75 && max_body_len == 32'hFFFF_FFFF)) begin
        cap = (max_body_len > 32'd24) ? 32'd24 : max_body_len;
        if (max_body_len <= 32'd200 && $urandom_range(0, 5) == 0) len = max_body_len;
        else len = $urandom_range(0, cap);
        send_frame(len, int'(len));
      end else if (pick < 75) begin
        if ($urandom_range(0, 2) == 0) len = max_body_len + 32'd1;
        else len = max_body_len + 32'd1 + ($urandom() % (32'hFFFF_FFFF - max_body_len));
        send_frame(len, 0);
      end else if (pick < 87) begin
        // Second marker byte wrong: it is dropped, whatever it is.
        do b = 8'($urandom()); while (b == lpfp_pkg::MARK_SECOND);
        if ($urandom_range(0, 3) == 0) b = lpfp_pkg::MARK_FIRST;
        send_byte(lpfp_pkg::MARK_FIRST, 1'b0, 1'b0, NO_RESULT);
        send_byte(b, 1'b0, 1'b0, NO_RESULT);
      end else begin
        // Stray bytes between frames; a first marker here would open a frame
        // with an arbitrary length, so it is kept out.
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom()); while (b == lpfp_pkg::MARK_FIRST);
          send_byte(b, 1'b0, 1'b0, NO_RESULT);
        end
      end
    end
  endtask

  // Result checker: every item taken from frame_out must match the oldest expectation.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && frame_out.valid && frame_out.ready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result status=%0d byte=%h last=%b",
                             frame_out.status, frame_out.body_byte, frame_out.body_last));
      end else begin
        want = pending_results.pop_front();
        if (frame_out.status !== want.status) begin
          note_error($sformatf("status %0d, expected %0d", frame_out.status, want.status));
        end
        if (frame_out.body_byte !== want.body_byte) begin
          note_error($sformatf("body_byte %h, expected %h",
                               frame_out.body_byte, want.body_byte));
        end
        if (frame_out.body_last !== want.body_last) begin
          note_error($sformatf("body_last %b, expected %b",
                               frame_out.body_last, want.body_last));
        end
      end
    end
  end

  // Receiver: random stall bursts, open stretches, and one long hold-off on request
  // so that the result register fills and the parser pushes back on its input.
  initial begin
    frame_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        frame_out.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        frame_out.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        frame_out.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("length_prefixed_frame_parser_top verification failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    byte_in.valid <= 1'b0;
    byte_in.data_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    error_count = 0;
    frame_items = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    parse_phase = lpfp_pkg::PH_HUNT;
    len_accum = '0;
    len_count = '0;
    body_left = '0;
    max_body_len = lpfp_pkg::MAX_BODY_LENGTH_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The limit comes out of reset at its default.
    check_max_len();

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].has_result,
                DIRECTED[i].result);
    end

    // Lowest limit: every frame with a body is oversize.
    drain_results();
    apb_write(ADDR_MAX_LEN, 32'd0);
    check_max_len();
    run_traffic(100);

    // Highest limit: nothing is oversize. A long body is sent while the receiver
    // holds off, then the sender waits for everything to come out.
    drain_results();
    apb_write(ADDR_MAX_LEN, 32'hFFFF_FFFF);
    check_max_len();
    run_traffic(70);
    hold_req = 1'b1;
    send_frame(32'd80, 80);
    drain_results();
    run_traffic(60);

    // A write outside the register map leaves the limit alone; the limit is then set anew.
    drain_results();
    apb_write(ADDR_UNUSED, $urandom());
    apb_write(ADDR_MAX_LEN, $urandom_range(1, 20));
    check_max_len();
    run_traffic(170);

    drain_results();
    apb_write(ADDR_MAX_LEN, $urandom_range(21, 200));
    check_max_len();
    run_traffic(130);

    // Final stretch runs both sides flat out.
    drain_results();
    no_idle = 1'b1;
    apb_write(ADDR_MAX_LEN, $urandom_range(0, 12));
    check_max_len();
    run_traffic(150);

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("length_prefixed_frame_parser_top verification clean");
    end else begin
      $display("length_prefixed_frame_parser_top verification failed");
    end
    $finish;
  end

endmodule
